@@ rtl/dcdd_pkg.sv @@
package dcdd_pkg;

    // Field widths
    localparam int HEAD_W   = 64;
    localparam int TAIL_W   = 16;
    localparam int LEN_W    = 8;
    localparam int YEAR_W   = 14;
    localparam int CFG_IDX_W = 2;
    localparam int DAYS_W   = 22;
    localparam int NIGHTS_W = 23;
    localparam int ORDER_W  = 2;

    // Text format
    localparam int unsigned  DATE_LEN   = 10;
    localparam logic [7:0]   SLASH      = 8'h2F;
    localparam logic [7:0]   ASCII_ZERO = 8'h30;
    localparam logic [7:0]   ASCII_NINE = 8'h39;
    // Character positions that hold a separator rather than a digit
    localparam logic [9:0]   SEP_MASK   = 10'b00_0010_0100;

    // Calendar
    localparam logic [13:0]  YEAR_SHIFT  = 14'd400;
    localparam logic [6:0]   LAST_MONTH  = 7'd12;
    localparam logic [6:0]   FEB         = 7'd2;
    localparam logic [4:0]   FEB_LEAP    = 5'd29;
    localparam logic [4:0]   FEB_COMMON  = 5'd28;
    // floor(x / 25) for x < 2600 as (x * DIV25_MUL) >> 16
    localparam logic [11:0]  DIV25_MUL   = 12'd2622;
    localparam logic [8:0]   DAYS_PER_YEAR = 9'd365;

    // Register reset values
    localparam logic [YEAR_W-1:0] YEAR_MIN_RESET = 14'd1900;
    localparam logic [YEAR_W-1:0] YEAR_MAX_RESET = 14'd2100;

    // Result codes
    localparam logic signed [NIGHTS_W-1:0] NIGHTS_NONE  = '1;
    localparam logic signed [ORDER_W-1:0]  ORDER_BEFORE = 2'sb11;
    localparam logic signed [ORDER_W-1:0]  ORDER_SAME   = 2'sb00;
    localparam logic signed [ORDER_W-1:0]  ORDER_AFTER  = 2'sb01;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_YEAR_MIN = 2'd0,
        CFG_YEAR_MAX = 2'd1
    } cfg_index_t;

    // Load enables of the per-date pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } adv_t;

    // Days in a month; the month is known to be 1 to 12
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? FEB_LEAP : FEB_COMMON;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // Days before a month of a year that starts in March (mp 0 is March)
    function automatic logic [8:0] month_offset(input logic [3:0] mp);
        logic [8:0] ofs;
        case (mp)
            4'd0:    ofs = 9'd0;
            4'd1:    ofs = 9'd31;
            4'd2:    ofs = 9'd61;
            4'd3:    ofs = 9'd92;
            4'd4:    ofs = 9'd122;
            4'd5:    ofs = 9'd153;
            4'd6:    ofs = 9'd184;
            4'd7:    ofs = 9'd214;
            4'd8:    ofs = 9'd245;
            4'd9:    ofs = 9'd275;
            4'd10:   ofs = 9'd306;
            4'd11:   ofs = 9'd337;
            default: ofs = 9'd0;
        endcase
        return ofs;
    endfunction

endpackage

@@ rtl/dcdd_if.sv @@
interface dcdd_in_if;
    logic                          valid;
    logic                          ready;
    logic [dcdd_pkg::HEAD_W-1:0]   first_text_head;
    logic [dcdd_pkg::TAIL_W-1:0]   first_text_tail;
    logic [dcdd_pkg::LEN_W-1:0]    first_text_length;
    logic [dcdd_pkg::HEAD_W-1:0]   second_text_head;
    logic [dcdd_pkg::TAIL_W-1:0]   second_text_tail;
    logic [dcdd_pkg::LEN_W-1:0]    second_text_length;

    modport source (
        output valid, first_text_head, first_text_tail, first_text_length,
               second_text_head, second_text_tail, second_text_length,
        input  ready
    );
    modport sink (
        input  valid, first_text_head, first_text_tail, first_text_length,
               second_text_head, second_text_tail, second_text_length,
        output ready
    );
endinterface

interface dcdd_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [dcdd_pkg::NIGHTS_W-1:0] nights;
    logic signed [dcdd_pkg::ORDER_W-1:0]  order;
    logic                                 first_valid;
    logic                                 second_valid;

    modport source (
        output valid, nights, order, first_valid, second_valid,
        input  ready
    );
    modport sink (
        input  valid, nights, order, first_valid, second_valid,
        output ready
    );
endinterface

interface dcdd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dcdd_pkg::CFG_IDX_W-1:0] index;
    logic [dcdd_pkg::YEAR_W-1:0]    data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

@@ rtl/dcdd_date_unit.sv @@
module dcdd_date_unit (
    input  logic                         clk,
    input  dcdd_pkg::adv_t               adv,
    input  logic [dcdd_pkg::HEAD_W-1:0]  text_head,
    input  logic [dcdd_pkg::TAIL_W-1:0]  text_tail,
    input  logic [dcdd_pkg::LEN_W-1:0]   text_length,
    input  logic [dcdd_pkg::YEAR_W-1:0]  year_min,
    input  logic [dcdd_pkg::YEAR_W-1:0]  year_max,
    output logic                         date_valid,
    output logic [dcdd_pkg::DAYS_W-1:0]  day_count
);

    logic [7:0] ch  [10];
    logic [3:0] dig [10];
    logic [9:0] is_dig;
    logic [6:0] cd;
    logic [6:0] ab;

    // Stage 1: parsed fields
    logic        s1_fmt_reg,  s1_fmt_next;
    logic        s1_leap_reg, s1_leap_next;
    logic [6:0]  s1_d_reg,    s1_d_next;
    logic [6:0]  s1_m_reg,    s1_m_next;
    logic [13:0] s1_y_reg,    s1_y_next;

    // Stage 2: checked date, shifted year and its century count
    logic        s2_ok_reg,   s2_ok_next;
    logic [13:0] s2_yr_reg,   s2_yr_next;
    logic [6:0]  s2_q100_reg, s2_q100_next;
    logic [8:0]  s2_doy_reg,  s2_doy_next;

    // Stage 3: day number
    logic                         s3_ok_reg,   s3_ok_next;
    logic [dcdd_pkg::DAYS_W-1:0]  s3_days_reg, s3_days_next;

    logic        win_ok, mon_ok, day_ok;
    logic [3:0]  mp;
    logic [4:0]  mlen;
    logic [23:0] q_prod;

    // Split text into characters, character 0 in the top byte
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            ch[i] = text_head[(7 - i) * 8 +: 8];
        end
        ch[8] = text_tail[15:8];
        ch[9] = text_tail[7:0];
        for (int i = 0; i < 10; i++)
        begin
            is_dig[i] = (ch[i] >= dcdd_pkg::ASCII_ZERO) && (ch[i] <= dcdd_pkg::ASCII_NINE);
            dig[i]    = ch[i][3:0];
        end
    end

    always_comb
    begin
        s1_fmt_next = (text_length == 8'(dcdd_pkg::DATE_LEN))
                   && (ch[2] == dcdd_pkg::SLASH) && (ch[5] == dcdd_pkg::SLASH)
                   && ((is_dig | dcdd_pkg::SEP_MASK) == '1);
        s1_d_next = 7'(dig[0]) * 7'd10 + 7'(dig[1]);
        s1_m_next = 7'(dig[3]) * 7'd10 + 7'(dig[4]);
        s1_y_next = 14'(dig[6]) * 14'd1000 + 14'(dig[7]) * 14'd100
                  + 14'(dig[8]) * 14'd10 + 14'(dig[9]);
        // Leap from the digit pairs: low pair picks div-by-4 and div-by-100
        cd = 7'(dig[8]) * 7'd10 + 7'(dig[9]);
        ab = 7'(dig[6]) * 7'd10 + 7'(dig[7]);
        s1_leap_next = ((cd[1:0] == 2'd0) && (cd != 7'd0))
                    || ((cd == 7'd0) && (ab[1:0] == 2'd0));
    end

    always_comb
    begin
        win_ok = (s1_y_reg >= year_min) && (s1_y_reg <= year_max);
        mon_ok = (s1_m_reg >= 7'd1) && (s1_m_reg <= dcdd_pkg::LAST_MONTH);
        mlen   = dcdd_pkg::month_len(s1_m_reg[3:0], s1_leap_reg);
        day_ok = (s1_d_reg >= 7'd1) && (s1_d_reg <= 7'(mlen));
        s2_ok_next = s1_fmt_reg && win_ok && mon_ok && day_ok;

        // January and February count with the previous year
        s2_yr_next = s1_y_reg + dcdd_pkg::YEAR_SHIFT
                   - 14'((s1_m_reg <= dcdd_pkg::FEB) ? 1 : 0);
        mp = (s1_m_reg > dcdd_pkg::FEB) ? 4'(s1_m_reg - 7'd3) : 4'(s1_m_reg + 7'd9);
        s2_doy_next = dcdd_pkg::month_offset(mp) + 9'(s1_d_reg) - 9'd1;

        // floor(yr / 100) = floor((yr >> 2) / 25)
        q_prod = 24'(s2_yr_next[13:2]) * 24'(dcdd_pkg::DIV25_MUL);
        s2_q100_next = q_prod[22:16];
    end

    always_comb
    begin
        s3_ok_next   = s2_ok_reg;
        s3_days_next = 22'(s2_yr_reg) * 22'(dcdd_pkg::DAYS_PER_YEAR)
                     + 22'(s2_yr_reg[13:2]) - 22'(s2_q100_reg)
                     + 22'(s2_q100_reg[6:2]) + 22'(s2_doy_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            s1_fmt_reg  <= s1_fmt_next;
            s1_leap_reg <= s1_leap_next;
            s1_d_reg    <= s1_d_next;
            s1_m_reg    <= s1_m_next;
            s1_y_reg    <= s1_y_next;
        end
        if (adv.s2)
        begin
            s2_ok_reg   <= s2_ok_next;
            s2_yr_reg   <= s2_yr_next;
            s2_q100_reg <= s2_q100_next;
            s2_doy_reg  <= s2_doy_next;
        end
        if (adv.s3)
        begin
            s3_ok_reg   <= s3_ok_next;
            s3_days_reg <= s3_days_next;
        end
    end

    assign date_valid = s3_ok_reg;
    assign day_count  = s3_days_reg;

endmodule

@@ rtl/date_check_and_day_difference.sv @@
// Pipeline: input register, three date stages and output register, in that order.
// Throughput: one pair of dates per cycle while results are taken; every stage holds
//   one request and moves on as soon as the stage after it is free, so a full
//   pipeline streams without gaps.
// Reset: stage valid flags clear and year_min/year_max return to 1900/2100.
module date_check_and_day_difference (
    input  logic      clk,
    input  logic      rst_n,
    dcdd_in_if.sink   dates,
    dcdd_out_if.source result,
    dcdd_cfg_if.sink  cfg
);

    // ------------------------------------------------------------------
    // Configuration registers: writes are always accepted and registered.
    // Indexes beyond the register list are dropped.
    // ------------------------------------------------------------------
    logic [dcdd_pkg::YEAR_W-1:0] year_min_reg, year_min_next;
    logic [dcdd_pkg::YEAR_W-1:0] year_max_reg, year_max_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        year_min_next = year_min_reg;
        year_max_next = year_max_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                dcdd_pkg::CFG_YEAR_MIN: year_min_next = cfg.data;
                dcdd_pkg::CFG_YEAR_MAX: year_max_next = cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_min_reg <= dcdd_pkg::YEAR_MIN_RESET;
            year_max_reg <= dcdd_pkg::YEAR_MAX_RESET;
        end
        else
        begin
            year_min_reg <= year_min_next;
            year_max_reg <= year_max_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage may load when it is empty or
    // when the stage after it loads in the same cycle; the output
    // register frees when the consumer takes the result.
    // ------------------------------------------------------------------
    logic in_vld_reg,  in_vld_next;
    logic s1_vld_reg,  s1_vld_next;
    logic s2_vld_reg,  s2_vld_next;
    logic s3_vld_reg,  s3_vld_next;
    logic out_vld_reg, out_vld_next;

    logic rdy_in, rdy_s1, rdy_s2, rdy_s3, rdy_out;
    dcdd_pkg::adv_t adv;

    assign rdy_out = !out_vld_reg || result.ready;
    assign rdy_s3  = !s3_vld_reg  || rdy_out;
    assign rdy_s2  = !s2_vld_reg  || rdy_s3;
    assign rdy_s1  = !s1_vld_reg  || rdy_s2;
    assign rdy_in  = !in_vld_reg  || rdy_s1;

    assign dates.ready = rdy_in;

    assign adv.s1 = rdy_s1;
    assign adv.s2 = rdy_s2;
    assign adv.s3 = rdy_s3;

    always_comb
    begin
        // advance each valid flag only when its stage loads, else hold
        in_vld_next  = rdy_in  ? dates.valid : in_vld_reg;
        s1_vld_next  = rdy_s1  ? in_vld_reg  : s1_vld_reg;
        s2_vld_next  = rdy_s2  ? s1_vld_reg  : s2_vld_reg;
        s3_vld_next  = rdy_s3  ? s2_vld_reg  : s3_vld_reg;
        out_vld_next = rdy_out ? s3_vld_reg  : out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            s1_vld_reg  <= s1_vld_next;
            s2_vld_reg  <= s2_vld_next;
            s3_vld_reg  <= s3_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // ------------------------------------------------------------------
    // Input register: capture the request payload.
    // ------------------------------------------------------------------
    logic [dcdd_pkg::HEAD_W-1:0] first_head_reg,  first_head_next;
    logic [dcdd_pkg::TAIL_W-1:0] first_tail_reg,  first_tail_next;
    logic [dcdd_pkg::LEN_W-1:0]  first_len_reg,   first_len_next;
    logic [dcdd_pkg::HEAD_W-1:0] second_head_reg, second_head_next;
    logic [dcdd_pkg::TAIL_W-1:0] second_tail_reg, second_tail_next;
    logic [dcdd_pkg::LEN_W-1:0]  second_len_reg,  second_len_next;

    always_comb
    begin
        first_head_next  = dates.first_text_head;
        first_tail_next  = dates.first_text_tail;
        first_len_next   = dates.first_text_length;
        second_head_next = dates.second_text_head;
        second_tail_next = dates.second_text_tail;
        second_len_next  = dates.second_text_length;
    end

    always_ff @(posedge clk)
    begin
        if (rdy_in)
        begin
            first_head_reg  <= first_head_next;
            first_tail_reg  <= first_tail_next;
            first_len_reg   <= first_len_next;
            second_head_reg <= second_head_next;
            second_tail_reg <= second_tail_next;
            second_len_reg  <= second_len_next;
        end
    end

    // ------------------------------------------------------------------
    // Date stages: format check and parse, calendar check and year
    // split, then the day number counted from 400 years before year 0.
    // ------------------------------------------------------------------
    logic                        first_ok,  second_ok;
    logic [dcdd_pkg::DAYS_W-1:0] first_days, second_days;

    dcdd_date_unit u_first (
        .clk         (clk),
        .adv         (adv),
        .text_head   (first_head_reg),
        .text_tail   (first_tail_reg),
        .text_length (first_len_reg),
        .year_min    (year_min_reg),
        .year_max    (year_max_reg),
        .date_valid  (first_ok),
        .day_count   (first_days)
    );

    dcdd_date_unit u_second (
        .clk         (clk),
        .adv         (adv),
        .text_head   (second_head_reg),
        .text_tail   (second_tail_reg),
        .text_length (second_len_reg),
        .year_min    (year_min_reg),
        .year_max    (year_max_reg),
        .date_valid  (second_ok),
        .day_count   (second_days)
    );

    // ------------------------------------------------------------------
    // Output register: difference and ordering of the two day numbers.
    // Nights is the plain difference only when the second date is later;
    // any invalid date forces nights to -1 and order to 0.
    // ------------------------------------------------------------------
    logic signed [dcdd_pkg::NIGHTS_W-1:0] nights_reg, nights_next;
    logic signed [dcdd_pkg::ORDER_W-1:0]  order_reg,  order_next;
    logic                                 first_valid_reg,  first_valid_next;
    logic                                 second_valid_reg, second_valid_next;
    logic [dcdd_pkg::DAYS_W-1:0]          day_diff;

    always_comb
    begin
        day_diff          = second_days - first_days;
        nights_next       = dcdd_pkg::NIGHTS_NONE;
        order_next        = dcdd_pkg::ORDER_SAME;
        first_valid_next  = first_ok;
        second_valid_next = second_ok;
        if (first_ok && second_ok)
        begin
            if (second_days > first_days)
            begin
                nights_next = {1'b0, day_diff};
                order_next  = dcdd_pkg::ORDER_BEFORE;
            end
            else if (second_days < first_days)
            begin
                order_next  = dcdd_pkg::ORDER_AFTER;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_out)
        begin
            nights_reg       <= nights_next;
            order_reg        <= order_next;
            first_valid_reg  <= first_valid_next;
            second_valid_reg <= second_valid_next;
        end
    end

    assign result.valid        = out_vld_reg;
    assign result.nights       = nights_reg;
    assign result.order        = order_reg;
    assign result.first_valid  = first_valid_reg;
    assign result.second_valid = second_valid_reg;

endmodule
